[rtl/core/midiusb_pkg.sv]
// shared types and constants for the midi to usb event packetizer
// no dependencies; imported by the top level and the checker

package midiusb_pkg;

  // number of midi input ports with parser state
  localparam int NUM_PORTS = 4;

  // status byte values
  localparam logic [7:0] ST_SYSEX_START  = 8'hF0;
  localparam logic [7:0] ST_MTC_QUARTER  = 8'hF1;
  localparam logic [7:0] ST_SONG_POS     = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL     = 8'hF3;
  localparam logic [7:0] ST_SYSEX_END    = 8'hF7;
  localparam logic [7:0] ST_REALTIME_MIN = 8'hF8;
  localparam logic [7:0] ST_SYSTEM_MIN   = 8'hF0;
  localparam logic [7:0] ST_NONE         = 8'h00;

  // channel voice high nibbles with a single data byte
  localparam logic [3:0] NIB_PROG_CHANGE = 4'hC;
  localparam logic [3:0] NIB_CHAN_PRESS  = 4'hD;

  // usb-midi code index numbers
  localparam logic [3:0] CIN_SYS_TWO     = 4'h2;
  localparam logic [3:0] CIN_SYS_THREE   = 4'h3;
  localparam logic [3:0] CIN_SYSEX_CONT  = 4'h4;
  localparam logic [3:0] CIN_SINGLE_END  = 4'h5;
  localparam logic [3:0] CIN_REALTIME    = 4'hF;

  // input transaction payload
  typedef struct packed {
    logic [1:0] port;
    logic [7:0] midi_byte;
  } in_item_t;

  // output transaction payload: one usb-midi event packet
  typedef struct packed {
    logic [3:0] cable;
    logic [3:0] code_index;
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
  } out_item_t;

endpackage

[rtl/core/midi_to_usb_event_packetizer.sv]
// midi to usb-midi 1.0 event packetizer, top level
// depends on midiusb_pkg for payload types and code constants

// Takes one raw MIDI byte per transaction, tagged with its input port, and
// emits zero or one 4-byte USB-MIDI event packet (cable, code index, three
// bytes). Each port keeps its own running status, pending data byte and
// SysEx chunk buffer. The block accepts a new byte every clock cycle while
// the input register is empty or can advance: a byte is taken into an input
// register, then the port's state is read, updated and the packet is written
// to the output register, which drives out_valid and out_data. The rate of
// one byte per cycle is set by the read-modify-write of the per-port state
// registers. Bytes that produce no packet still take one pass through the
// input register. The output register holds a packet while out_ready is
// low, and input flow stops only when both registers are full.

module midi_to_usb_event_packetizer (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  midiusb_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output midiusb_pkg::out_item_t out_data
);
  import midiusb_pkg::*;

  // input stage
  logic      in_valid_r;
  in_item_t  in_item_r;

  // output stage
  logic      out_valid_r;
  out_item_t out_item_r;

  // per-port parser state
  logic [7:0] running_status_r [NUM_PORTS];
  logic [3:0] pending_code_r   [NUM_PORTS];
  logic       needs_two_r      [NUM_PORTS];
  logic       have_first_r     [NUM_PORTS];
  logic [6:0] first_data_r     [NUM_PORTS];
  logic       sysex_open_r     [NUM_PORTS];
  logic [1:0] sysex_count_r    [NUM_PORTS];
  logic [7:0] sysex_buffer_r   [NUM_PORTS][3];

  // next values for the port being served
  logic [7:0] rs_nxt;
  logic [3:0] pc_nxt;
  logic       n2_nxt;
  logic       hf_nxt;
  logic [6:0] fd_nxt;
  logic       so_nxt;
  logic [1:0] sc_nxt;
  logic [7:0] buf_nxt [3];
  logic       emit;
  out_item_t  pkt;

  logic       advance;
  logic       port_ok;
  logic [1:0] p;
  logic [7:0] b;

  assign p       = in_item_r.port;
  assign b       = in_item_r.midi_byte;
  assign port_ok = (int'(p) < NUM_PORTS);
  assign advance = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // parser decision for the byte in the input register
  always_comb begin
    logic [1:0] idx;
    logic [3:0] nib;
    rs_nxt  = running_status_r[p];
    pc_nxt  = pending_code_r[p];
    n2_nxt  = needs_two_r[p];
    hf_nxt  = have_first_r[p];
    fd_nxt  = first_data_r[p];
    so_nxt  = sysex_open_r[p];
    sc_nxt  = sysex_count_r[p];
    for (int i = 0; i < 3; i++) begin
      buf_nxt[i] = sysex_buffer_r[p][i];
    end
    idx  = (sysex_count_r[p] == 2'd3) ? 2'd2 : sysex_count_r[p];
    nib  = b[7:4];
    emit = 1'b0;
    pkt  = '0;
    pkt.cable = {2'b00, p};

    priority if (b >= ST_REALTIME_MIN) begin
      // real-time passes straight through
      emit = 1'b1;
      pkt.code_index = CIN_REALTIME;
      pkt.byte_zero  = b;
    end else if (b == ST_SYSEX_START) begin
      rs_nxt     = ST_NONE;
      hf_nxt     = 1'b0;
      so_nxt     = 1'b1;
      buf_nxt[0] = ST_SYSEX_START;
      sc_nxt     = 2'd1;
    end else if (b == ST_SYSEX_END) begin
      rs_nxt = ST_NONE;
      emit   = 1'b1;
      if (sysex_open_r[p]) begin
        // close sysex with a 1, 2 or 3 byte end packet
        buf_nxt[idx]   = ST_SYSEX_END;
        so_nxt         = 1'b0;
        sc_nxt         = 2'd0;
        pkt.code_index = CIN_SINGLE_END + {2'b00, idx};
        pkt.byte_zero  = buf_nxt[0];
        pkt.byte_one   = (idx >= 2'd1) ? buf_nxt[1] : 8'h00;
        pkt.byte_two   = (idx >= 2'd2) ? buf_nxt[2] : 8'h00;
      end else begin
        // stray end of exclusive
        pkt.code_index = CIN_SINGLE_END;
        pkt.byte_zero  = ST_SYSEX_END;
      end
    end else if (b[7]) begin
      // any other status aborts sysex and the held data byte
      so_nxt = 1'b0;
      sc_nxt = 2'd0;
      hf_nxt = 1'b0;
      priority if (b < ST_SYSTEM_MIN) begin
        rs_nxt = b;
        pc_nxt = nib;
        n2_nxt = !(nib == NIB_PROG_CHANGE || nib == NIB_CHAN_PRESS);
      end else if (b == ST_MTC_QUARTER || b == ST_SONG_SEL) begin
        rs_nxt = b;
        pc_nxt = CIN_SYS_TWO;
        n2_nxt = 1'b0;
      end else if (b == ST_SONG_POS) begin
        rs_nxt = b;
        pc_nxt = CIN_SYS_THREE;
        n2_nxt = 1'b1;
      end else begin
        // tune request and undefined system common go out as singles
        rs_nxt         = ST_NONE;
        emit           = 1'b1;
        pkt.code_index = CIN_SINGLE_END;
        pkt.byte_zero  = b;
      end
    end else if (sysex_open_r[p]) begin
      // sysex data, full chunk goes out every third byte
      buf_nxt[idx] = b;
      if (idx == 2'd2) begin
        sc_nxt         = 2'd0;
        emit           = 1'b1;
        pkt.code_index = CIN_SYSEX_CONT;
        pkt.byte_zero  = buf_nxt[0];
        pkt.byte_one   = buf_nxt[1];
        pkt.byte_two   = buf_nxt[2];
      end else begin
        sc_nxt = idx + 2'd1;
      end
    end else if (running_status_r[p] == ST_NONE) begin
      // data with no status is dropped
    end else if (needs_two_r[p] && !have_first_r[p]) begin
      fd_nxt = b[6:0];
      hf_nxt = 1'b1;
    end else begin
      // message complete
      hf_nxt         = 1'b0;
      emit           = 1'b1;
      pkt.code_index = pending_code_r[p];
      pkt.byte_zero  = running_status_r[p];
      if (running_status_r[p] >= ST_SYSTEM_MIN) begin
        rs_nxt = ST_NONE;
      end
      if (needs_two_r[p]) begin
        pkt.byte_one = {1'b0, first_data_r[p]};
        pkt.byte_two = b;
      end else begin
        pkt.byte_one = b;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit && port_ok;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (advance && emit && port_ok) begin
      out_item_r <= pkt;
    end
  end

  // per-port state with reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        running_status_r[i] <= ST_NONE;
        have_first_r[i]     <= 1'b0;
        sysex_open_r[i]     <= 1'b0;
        sysex_count_r[i]    <= 2'd0;
      end
    end else if (advance && port_ok) begin
      running_status_r[p] <= rs_nxt;
      have_first_r[p]     <= hf_nxt;
      sysex_open_r[p]     <= so_nxt;
      sysex_count_r[p]    <= sc_nxt;
    end
  end

  // per-port state that is written before it is read
  always_ff @(posedge clk) begin
    if (advance && port_ok) begin
      pending_code_r[p] <= pc_nxt;
      needs_two_r[p]    <= n2_nxt;
      first_data_r[p]   <= fd_nxt;
      for (int i = 0; i < 3; i++) begin
        sysex_buffer_r[p][i] <= buf_nxt[i];
      end
    end
  end

endmodule

[rtl/core/midiusb_checker.sv]
// port-level checks for the midi to usb event packetizer
// depends on midiusb_pkg; bound to midi_to_usb_event_packetizer below

module midiusb_checker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  midiusb_pkg::in_item_t  in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  midiusb_pkg::out_item_t out_data
);
  import midiusb_pkg::*;

  // a stalled packet stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("packet dropped while stalled");

  // a stalled packet keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("packet changed while stalled");

  // cable follows a 2-bit port
  a_cable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.cable[3:2] == 2'b00)
    else $error("cable out of range");

  // real-time packets carry a real-time byte and nothing else
  a_realtime: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.code_index == CIN_REALTIME |->
      out_data.byte_zero >= ST_REALTIME_MIN && out_data.byte_one == 8'h00
      && out_data.byte_two == 8'h00)
    else $error("bad real-time packet");

  // a real-time byte accepted with an idle pipeline appears after the input and output registers
  a_rt_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid && in_data.midi_byte >= ST_REALTIME_MIN
    ##1 !out_valid |=> out_valid && out_data.code_index == CIN_REALTIME)
    else $error("real-time byte lost");

endmodule

bind midi_to_usb_event_packetizer midiusb_checker u_midiusb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[bench/usb_packet_checker_pkg.sv]
// usb-midi event packet predictor and checker for the packetizer bench
// depends on midiusb_pkg for payload types, status values and code index numbers
`timescale 1ns / 100ps

package usb_packet_checker_pkg;
  import midiusb_pkg::*;

  class usb_packet_checker;
    // per-port parser state mirrored from the midi byte stream
    logic [7:0] status_byte [NUM_PORTS];
    logic [3:0] message_code [NUM_PORTS];
    bit         two_data [NUM_PORTS];
    bit         first_held [NUM_PORTS];
    logic [6:0] held_data [NUM_PORTS];
    bit         sysex_active [NUM_PORTS];
    int unsigned sysex_fill [NUM_PORTS];
    logic [7:0] sysex_bytes [NUM_PORTS][3];

    out_item_t   pending_packets[$];
    int unsigned mismatches;

    function new();
      for (int p = 0; p < NUM_PORTS; p++) begin
        status_byte[p]  = ST_NONE;
        message_code[p] = '0;
        two_data[p]     = 1'b0;
        first_held[p]   = 1'b0;
        held_data[p]    = '0;
        sysex_active[p] = 1'b0;
        sysex_fill[p]   = 0;
        for (int k = 0; k < 3; k++) sysex_bytes[p][k] = '0;
      end
      mismatches = 0;
    endfunction

    function void push_packet(logic [1:0] p, logic [3:0] code, logic [7:0] b0,
                              logic [7:0] b1, logic [7:0] b2);
      out_item_t pkt;
      pkt.cable      = {2'b00, p};
      pkt.code_index = code;
      pkt.byte_zero  = b0;
      pkt.byte_one   = b1;
      pkt.byte_two   = b2;
      pending_packets.push_back(pkt);
    endfunction

    // update one port's parser with an accepted byte and queue any packet it makes
    function void take_midi_byte(in_item_t item);
      logic [1:0] p;
      logic [7:0] b;
      logic [7:0] st;
      int unsigned n;
      p = item.port;
      b = item.midi_byte;

      // real-time passes straight through
      if (b >= ST_REALTIME_MIN) begin
        push_packet(p, CIN_REALTIME, b, 8'h00, 8'h00);
        return;
      end

      // status bytes
      if (b[7]) begin
        if (b == ST_SYSEX_START) begin
          status_byte[p]    = ST_NONE;
          first_held[p]     = 1'b0;
          sysex_active[p]   = 1'b1;
          sysex_bytes[p][0] = ST_SYSEX_START;
          sysex_fill[p]     = 1;
          return;
        end
        if (b == ST_SYSEX_END) begin
          status_byte[p] = ST_NONE;
          if (sysex_active[p]) begin
            n = sysex_fill[p];
            sysex_bytes[p][n] = ST_SYSEX_END;
            n++;
            sysex_active[p] = 1'b0;
            sysex_fill[p]   = 0;
            push_packet(p, CIN_SYSEX_CONT + 4'(n), sysex_bytes[p][0],
                        (n > 1) ? sysex_bytes[p][1] : 8'h00,
                        (n > 2) ? sysex_bytes[p][2] : 8'h00);
          end else begin
            // stray end of sysex goes out as a single
            push_packet(p, CIN_SINGLE_END, ST_SYSEX_END, 8'h00, 8'h00);
          end
          return;
        end
        // any other status aborts sysex and drops a held data byte
        sysex_active[p] = 1'b0;
        sysex_fill[p]   = 0;
        first_held[p]   = 1'b0;
        if (b < ST_SYSTEM_MIN) begin
          status_byte[p]  = b;
          message_code[p] = b[7:4];
          two_data[p]     = !(b[7:4] == NIB_PROG_CHANGE || b[7:4] == NIB_CHAN_PRESS);
        end else if (b == ST_MTC_QUARTER || b == ST_SONG_SEL) begin
          status_byte[p]  = b;
          message_code[p] = CIN_SYS_TWO;
          two_data[p]     = 1'b0;
        end else if (b == ST_SONG_POS) begin
          status_byte[p]  = b;
          message_code[p] = CIN_SYS_THREE;
          two_data[p]     = 1'b1;
        end else begin
          // tune request and the undefined system commons
          status_byte[p] = ST_NONE;
          push_packet(p, CIN_SINGLE_END, b, 8'h00, 8'h00);
        end
        return;
      end

      // data byte inside sysex fills the chunk buffer
      if (sysex_active[p]) begin
        n = sysex_fill[p];
        sysex_bytes[p][n] = b;
        n++;
        if (n == 3) begin
          sysex_fill[p] = 0;
          push_packet(p, CIN_SYSEX_CONT, sysex_bytes[p][0], sysex_bytes[p][1],
                      sysex_bytes[p][2]);
        end else begin
          sysex_fill[p] = n;
        end
        return;
      end

      // data with no status is dropped
      if (status_byte[p] == ST_NONE) return;

      if (two_data[p] && !first_held[p]) begin
        held_data[p]  = b[6:0];
        first_held[p] = 1'b1;
        return;
      end

      // message complete; system common cancels running status
      st = status_byte[p];
      first_held[p] = 1'b0;
      if (st >= ST_SYSTEM_MIN) status_byte[p] = ST_NONE;
      if (two_data[p])
        push_packet(p, message_code[p], st, {1'b0, held_data[p]}, b);
      else
        push_packet(p, message_code[p], st, b, 8'h00);
    endfunction

    // compare one accepted packet with the oldest expected one
    function void check_packet(out_item_t got);
      out_item_t want;
      if (pending_packets.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected packet: cable %0d cin %h bytes %h %h %h",
                   got.cable, got.code_index, got.byte_zero, got.byte_one, got.byte_two);
        return;
      end
      want = pending_packets.pop_front();
      if (got.cable !== want.cable || got.code_index !== want.code_index ||
          got.byte_zero !== want.byte_zero || got.byte_one !== want.byte_one ||
          got.byte_two !== want.byte_two) begin
        mismatches++;
        if (mismatches <= 10)
          $display("packet mismatch: expected %0d %h %h %h %h, actual %0d %h %h %h %h",
                   want.cable, want.code_index, want.byte_zero, want.byte_one,
                   want.byte_two, got.cable, got.code_index, got.byte_zero,
                   got.byte_one, got.byte_two);
      end
    endfunction

    function int unsigned outstanding();
      return pending_packets.size();
    endfunction

    function int unsigned failures();
      return mismatches + pending_packets.size();
    endfunction
  endclass

endpackage

[bench/tb_top.sv]
// top-level bench for midi_to_usb_event_packetizer: directed and random midi streams
// depends on midiusb_pkg and usb_packet_checker_pkg
`timescale 1ns / 100ps

module tb_top;
  import midiusb_pkg::*;
  import usb_packet_checker_pkg::*;

  localparam int RANDOM_ITEMS = 1800;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 10;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  usb_packet_checker packet_checker = new();

  int unsigned bytes_sent       = 0;
  int unsigned quiet_cycles     = 0;
  int unsigned hold_left        = 0;
  bit          gaps_on          = 1'b1;
  bit          pressure_trigger = 1'b0;
  bit          hold_taken       = 1'b0;

  midi_to_usb_event_packetizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: random stalls, one long hold, check each transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) packet_checker.check_packet(out_data);
    if (pressure_trigger && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(gaps_on && $urandom_range(0, 99) < 15);
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one byte, with a random gap first, and wait for the transaction
  task automatic send_byte(input logic [1:0] p, input logic [7:0] b);
    in_item_t item;
    item.port      = p;
    item.midi_byte = b;
    while (gaps_on && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    packet_checker.take_midi_byte(item);
    bytes_sent++;
  endtask

  // data byte, sometimes preceded by a real-time byte or a random byte on a random port
  task automatic send_data(input logic [1:0] p);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5)
      send_byte(p, 8'($urandom_range(ST_REALTIME_MIN, 8'hFF)));
    else if (roll < 10)
      send_byte(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    send_byte(p, 8'($urandom_range(0, 127)));
  endtask

  // one well-formed message with random content, or some noise
  task automatic send_random_message();
    logic [1:0] p;
    logic [7:0] st;
    int kind;
    int len;
    p    = 2'($urandom_range(0, 3));
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      // channel voice with running status repeats
      st = 8'($urandom_range(8'h80, 8'hEF));
      send_byte(p, st);
      repeat ($urandom_range(1, 4)) begin
        send_data(p);
        if (!(st[7:4] == NIB_PROG_CHANGE || st[7:4] == NIB_CHAN_PRESS)) send_data(p);
      end
    end else if (kind < 60) begin
      // sysex, mostly closed, sometimes cut off by another status
      send_byte(p, ST_SYSEX_START);
      len = $urandom_range(0, 10);
      repeat (len) send_data(p);
      if ($urandom_range(0, 9) < 8)
        send_byte(p, ST_SYSEX_END);
      else
        send_byte(p, 8'($urandom_range(8'h80, 8'hF6)));
    end else if (kind < 72) begin
      // system common
      st = 8'($urandom_range(ST_MTC_QUARTER, 8'hF6));
      send_byte(p, st);
      if (st == ST_MTC_QUARTER || st == ST_SONG_SEL) begin
        send_data(p);
      end else if (st == ST_SONG_POS) begin
        send_data(p);
        send_data(p);
      end
    end else if (kind < 80) begin
      send_byte(p, 8'($urandom_range(ST_REALTIME_MIN, 8'hFF)));
    end else begin
      repeat ($urandom_range(1, 3))
        send_byte(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int unsigned random_start;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // data with no status right after reset
    send_byte(2'd3, 8'h45);
    // note on, then running status
    send_byte(2'd0, 8'h90); send_byte(2'd0, 8'h3C); send_byte(2'd0, 8'h7F);
    send_byte(2'd0, 8'h40); send_byte(2'd0, 8'h00);
    // one-data-byte channel message
    send_byte(2'd1, 8'hC5); send_byte(2'd1, 8'h7F);
    // song position with real-time in the middle, then data after it is done
    send_byte(2'd2, ST_SONG_POS); send_byte(2'd2, 8'h01);
    send_byte(2'd2, ST_REALTIME_MIN); send_byte(2'd2, 8'h02);
    send_byte(2'd2, 8'h05);
    // tune request, undefined system commons, stray end of sysex, top real-time
    send_byte(2'd0, 8'hF6); send_byte(2'd0, 8'hF4); send_byte(2'd0, 8'hF5);
    send_byte(2'd0, ST_SYSEX_END); send_byte(2'd0, 8'hFF);
    // sysex with a full chunk and a two-byte end
    send_byte(2'd1, ST_SYSEX_START); send_byte(2'd1, 8'h01); send_byte(2'd1, 8'h02);
    send_byte(2'd1, 8'h03); send_byte(2'd1, ST_SYSEX_END);
    // sysex aborted by pitch bend
    send_byte(2'd3, ST_SYSEX_START); send_byte(2'd3, 8'h11); send_byte(2'd3, 8'hEF);
    send_byte(2'd3, 8'h00); send_byte(2'd3, 8'h7F);

    // random traffic: hold-off early, a stretch with no idling later on
    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_ITEMS) begin
      gaps_on <= !(bytes_sent - random_start >= 800 && bytes_sent - random_start < 1100);
      if (bytes_sent - random_start >= 500) pressure_trigger <= 1'b1;
      send_random_message();
    end
    in_valid <= 1'b0;
    gaps_on  <= 1'b1;

    while (packet_checker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (packet_checker.failures() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
rtl/core/midiusb_pkg.sv
rtl/core/midi_to_usb_event_packetizer.sv
rtl/core/midiusb_checker.sv
bench/usb_packet_checker_pkg.sv
bench/tb_top.sv
